// ===== src/ptfd_pkg.sv =====
package ptfd_pkg;

  localparam int COORD_W     = 32;
  localparam int LEN_W       = 31;
  localparam int DIF_W       = COORD_W + 1;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int ROOT_W      = 34;
  localparam int PROD_W      = COORD_W + LEN_W;
  localparam int QUOT_W      = LEN_W;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_STAGES  = QUOT_W;
  localparam int PROD_DLY    = SQRT_STAGES + 1;
  localparam int SIDE_DLY    = SQRT_STAGES + 1 + DIV_STAGES;
  localparam int PIPE_DEPTH  = SIDE_DLY + 4;

  typedef struct packed {
    logic [COORD_W-1:0] res;
    logic               sat;
    logic [COORD_W-1:0] pt;
  } lane_out_t;

endpackage

// ===== src/ptfd_sqrt.sv =====
module ptfd_sqrt
  import ptfd_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  sum,
  output logic [ROOT_W-1:0] root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic [RAD_W-1:0]  rad  [0:SQRT_STAGES];
  logic [REM_W-1:0]  rem  [0:SQRT_STAGES];
  logic [ROOT_W-1:0] rt   [0:SQRT_STAGES];

  assign rad[0] = {{(RAD_W-SUM_W){1'b0}}, sum};
  assign rem[0] = '0;
  assign rt[0]  = '0;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] trial;
    logic             ge;
    assign r2    = {rem[k][REM_W-3:0], rad[k][RAD_W-1 -: 2]};
    assign trial = {1'b0, rt[k], 2'b01};
    assign ge    = r2 >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1] <= {rad[k][RAD_W-3:0], 2'b00};
        rem[k+1] <= ge ? r2 - trial : r2;
        rt[k+1]  <= {rt[k][ROOT_W-2:0], ge};
      end
    end
  end

  assign root = rt[SQRT_STAGES];

endmodule

// ===== src/ptfd_div.sv =====
module ptfd_div
  import ptfd_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [PROD_W-1:0] num,
  input  logic [ROOT_W-1:0] den,
  output logic [QUOT_W-1:0] quot
);

  localparam int CMP_W = ROOT_W + DIV_STAGES;

  logic [PROD_W-1:0] rem [0:DIV_STAGES];
  logic [ROOT_W-1:0] dv  [0:DIV_STAGES];
  logic [QUOT_W-1:0] q   [0:DIV_STAGES];

  assign rem[0] = num;
  assign dv[0]  = den;
  assign q[0]   = '0;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    localparam int SH = DIV_STAGES - 1 - k;
    logic [CMP_W-1:0] dsh;
    logic [CMP_W-1:0] rx;
    logic             ge;
    assign dsh = {{(CMP_W-ROOT_W){1'b0}}, dv[k]} << SH;
    assign rx  = {{(CMP_W-PROD_W){1'b0}}, rem[k]};
    assign ge  = rx >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? PROD_W'(rx - dsh) : rem[k];
        dv[k+1]  <= dv[k];
        q[k+1]   <= {q[k][QUOT_W-2:0], ge};
      end
    end
  end

  assign quot = q[DIV_STAGES];

endmodule

// ===== src/ptfd_lane.sv =====
module ptfd_lane
  import ptfd_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [COORD_W-1:0] pt,
  input  logic [COORD_W-1:0] ctr,
  input  logic [LEN_W-1:0]   len,
  input  logic [ROOT_W-1:0]  root,
  output logic [SQ_W-1:0]    sq,
  output lane_out_t          result
);

  typedef struct packed {
    logic               neg;
    logic [COORD_W-1:0] pt;
    logic [COORD_W-1:0] ctr;
  } side_t;

  logic [DIF_W-1:0]   dif;
  logic [DIF_W-1:0]   dif_abs;
  logic [COORD_W-1:0] mag_a;
  logic [LEN_W-1:0]   len_a;
  side_t              side_a;
  logic [PROD_W-1:0]  prod_b;
  side_t              side_b;
  logic [PROD_W-1:0]  prod_dly [0:PROD_DLY-1];
  side_t              side_dly [0:SIDE_DLY-1];
  logic [QUOT_W-1:0]  quot;
  side_t              side_e;
  logic [COORD_W+1:0] off;
  logic [COORD_W+1:0] total;

  assign dif     = {pt[COORD_W-1], pt} - {ctr[COORD_W-1], ctr};
  assign dif_abs = dif[DIF_W-1] ? -dif : dif;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a  <= dif_abs[COORD_W-1:0];
      len_a  <= len;
      side_a <= '{neg: dif[DIF_W-1], pt: pt, ctr: ctr};
      sq     <= SQ_W'(mag_a) * SQ_W'(mag_a);
      prod_b <= PROD_W'(mag_a) * PROD_W'(len_a);
      side_b <= side_a;
      prod_dly[0] <= prod_b;
      side_dly[0] <= side_b;
      for (int i = 1; i < PROD_DLY; i++) prod_dly[i] <= prod_dly[i-1];
      for (int i = 1; i < SIDE_DLY; i++) side_dly[i] <= side_dly[i-1];
    end
  end

  ptfd_div u_div (
    .clk  (clk),
    .en   (en),
    .num  (prod_dly[PROD_DLY-1]),
    .den  (root),
    .quot (quot)
  );

  assign side_e = side_dly[SIDE_DLY-1];
  assign off    = side_e.neg ? -{3'b000, quot} : {3'b000, quot};
  assign total  = {{2{side_e.ctr[COORD_W-1]}}, side_e.ctr} + off;

  always_ff @(posedge clk) begin
    if (en) begin
      result.pt <= side_e.pt;
      if ($signed(total) > $signed({3'b000, {(COORD_W-1){1'b1}}})) begin
        result.res <= {1'b0, {(COORD_W-1){1'b1}}};
        result.sat <= 1'b1;
      end else if ($signed(total) < $signed({3'b111, {(COORD_W-1){1'b0}}})) begin
        result.res <= {1'b1, {(COORD_W-1){1'b0}}};
        result.sat <= 1'b1;
      end else begin
        result.res <= total[COORD_W-1:0];
        result.sat <= 1'b0;
      end
    end
  end

endmodule

// ===== src/point_to_fixed_distance_3d.sv =====
// Moves a 3D point along the ray from a center to a given distance from it.
// Input channel s_*: one word carries point x/y/z, center x/y/z (signed
// Q16.16) and the target length (unsigned Q15.16). Output channel m_*: one
// word carries the moved point; tuser flags a point equal to the center
// (passed through unchanged) and a clamped coordinate.
// Each axis has its own lane for difference, square, scaling product and
// divider; the lane squares merge into one sum feeding a shared square root.
// Throughput: one word per cycle while the output is not stalled. The
// path runs through the 34-stage square root (one root bit a stage)
// followed by the 31-stage restoring divider (one quotient bit a stage).
// Reset (rst, synchronous) empties the pipeline and drops pending output.
// When the receiver stalls, a result waiting in the output register holds
// and the pipeline keeps running until one more result fills a skid stage;
// then the whole pipeline and s_tready hold until the output is taken.
module point_to_fixed_distance_3d
  import ptfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // point_x, point_y, point_z, center_x, center_y, center_z, target_length, pad
  input  logic [223:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_x, new_y, new_z
  output logic [95:0]  m_tdata,
  // degenerate, saturated
  output logic [1:0]   m_tuser
);

  typedef struct packed {
    logic [3*COORD_W-1:0] data;
    logic                 deg;
    logic                 sat;
  } res_t;

  logic               en;
  logic [COORD_W-1:0] pt_r  [0:2];
  logic [COORD_W-1:0] ctr_r [0:2];
  logic [LEN_W-1:0]   len_r;
  logic [SQ_W-1:0]    sq    [0:2];
  lane_out_t          lane  [0:2];
  logic [SUM_W-1:0]   sum;
  logic               deg_c;
  logic [ROOT_W-1:0]  root;
  logic               vld   [0:PIPE_DEPTH-1];
  logic               deg_dly [0:SIDE_DLY];
  res_t               fin;
  res_t               skid;
  logic               skid_valid;
  res_t               out;

  assign en       = !skid_valid;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pt_r[i]  <= s_tdata[i*COORD_W +: COORD_W];
        ctr_r[i] <= s_tdata[(i+3)*COORD_W +: COORD_W];
      end
      len_r <= s_tdata[6*COORD_W +: LEN_W];
      sum   <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      deg_dly[0] <= deg_c;
      for (int i = 1; i <= SIDE_DLY; i++) deg_dly[i] <= deg_dly[i-1];
    end
  end

  assign deg_c = (sq[0] == '0) && (sq[1] == '0) && (sq[2] == '0);

  for (genvar g = 0; g < 3; g++) begin : g_lane
    ptfd_lane u_lane (
      .clk    (clk),
      .en     (en),
      .pt     (pt_r[g]),
      .ctr    (ctr_r[g]),
      .len    (len_r),
      .root   (root),
      .sq     (sq[g]),
      .result (lane[g])
    );
  end

  ptfd_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .sum  (sum),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_DEPTH; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < PIPE_DEPTH; i++) vld[i] <= vld[i-1];
    end
  end

  always_comb begin
    fin.deg = deg_dly[SIDE_DLY];
    if (fin.deg) begin
      fin.data = {lane[2].pt, lane[1].pt, lane[0].pt};
      fin.sat  = 1'b0;
    end else begin
      fin.data = {lane[2].res, lane[1].res, lane[0].res};
      fin.sat  = lane[0].sat | lane[1].sat | lane[2].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        out        <= skid;
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out      <= fin;
        m_tvalid <= vld[PIPE_DEPTH-1];
      end
    end else if (vld[PIPE_DEPTH-1] && !skid_valid) begin
      skid       <= fin;
      skid_valid <= 1'b1;
    end
  end

  assign m_tdata = out.data;
  assign m_tuser = {out.sat, out.deg};

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import ptfd_pkg::*;

  typedef struct {
    logic [31:0] pt [3];
    logic [31:0] ctr [3];
    logic [30:0] len;
  } vec_in_t;

  typedef struct {
    logic [95:0] xyz;
    logic [1:0]  flags;
  } vec_out_t;

  localparam int STALL_LIMIT = 20000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [223:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;
  logic [1:0]   m_tuser;

  vec_out_t moved_q[$];
  int       err_cnt = 0;
  int       idle_cnt = 0;
  int       send_gap_pct = 0;
  int       recv_gap_pct = 0;
  bit       hold_off = 1'b0;
  bit       feed_done = 1'b0;

  point_to_fixed_distance_3d DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [127:0] isqrt(logic [127:0] s);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic vec_out_t predict_move(vec_in_t v);
    vec_out_t     o;
    logic signed [33:0] d [3];
    logic [63:0]  m [3];
    logic [127:0] s;
    logic [127:0] n;
    logic [127:0] q;
    logic signed [65:0] r;
    logic         sat;
    s = '0;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({v.pt[i][31], v.pt[i]}) - $signed({v.ctr[i][31], v.ctr[i]});
      m[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
      s += 128'(m[i]) * 128'(m[i]);
    end
    if (s == 0) begin
      o.xyz = {v.pt[2], v.pt[1], v.pt[0]};
      o.flags = 2'b01;
      return o;
    end
    n = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = (128'(m[i]) * 128'(v.len)) / n;
      r = $signed({{34{v.ctr[i][31]}}, v.ctr[i]});
      if (d[i] < 0) r = r - $signed({2'b0, q[63:0]});
      else r = r + $signed({2'b0, q[63:0]});
      if (r > 66'sd2147483647) begin
        r = 66'sd2147483647;
        sat = 1'b1;
      end else if (r < -66'sd2147483648) begin
        r = -66'sd2147483648;
        sat = 1'b1;
      end
      o.xyz[32*i +: 32] = r[31:0];
    end
    o.flags = {sat, 1'b0};
    return o;
  endfunction

  task automatic send_vec(vec_in_t v);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata <= {1'b0, v.len, v.ctr[2], v.ctr[1], v.ctr[0], v.pt[2], v.pt[1], v.pt[0]};
    s_tvalid <= 1'b1;
    moved_q = {moved_q, predict_move(v)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(2000) - 1000;
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(99)
                                       : 32'h8000_0000 + $urandom_range(99);
    endcase
  endfunction

  function automatic vec_in_t rand_vec();
    vec_in_t v;
    int mode;
    mode = $urandom_range(3);
    for (int i = 0; i < 3; i++) begin
      v.pt[i] = rand_coord(mode);
      v.ctr[i] = $urandom_range(9) == 0 ? v.pt[i] : rand_coord(mode);
    end
    case ($urandom_range(4))
      0: v.len = '0;
      1: v.len = 31'h7FFF_FFFF;
      2: v.len = $urandom_range(65536 * 4);
      default: v.len = $urandom();
    endcase
    return v;
  endfunction

  task automatic run_random(int cnt);
    for (int k = 0; k < cnt; k++) send_vec(rand_vec());
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (moved_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // directed table: point, center, length, expected coordinates (typed rows only)
  typedef struct {
    logic [31:0] p [3];
    logic [31:0] c [3];
    logic [30:0] len;
    logic [95:0] xyz;
    logic        typed;
  } row_t;

  row_t dir_tbl [12];

  initial begin
    vec_in_t v;
    vec_out_t chk;
    dir_tbl[0]  = '{'{32'd5, 32'd6, 32'd7}, '{32'd5, 32'd6, 32'd7}, 31'd100,
                    {32'd7, 32'd6, 32'd5}, 1'b1};
    dir_tbl[1]  = '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 31'h7FFF_FFFF,
                    {3{32'h8000_0000}}, 1'b1};
    dir_tbl[2]  = '{'{32'd10, 32'd20, 32'd30}, '{32'd1, 32'd2, 32'd3}, 31'd0,
                    {32'd3, 32'd2, 32'd1}, 1'b1};
    dir_tbl[3]  = '{'{32'h0001_0000, 32'd0, 32'd0}, '{32'd0, 32'd0, 32'd0},
                    31'h0002_0000, {32'd0, 32'd0, 32'h0002_0000}, 1'b1};
    dir_tbl[4]  = '{'{32'h7FFF_FFFF, 32'd0, 32'd0}, '{32'h7FFF_0000, 32'd0, 32'd0},
                    31'h7FFF_FFFF, {32'd0, 32'd0, 32'h7FFF_FFFF}, 1'b1};
    dir_tbl[5]  = '{'{32'h8000_0000, 32'd0, 32'd0}, '{32'h8000_0001, 32'd0, 32'd0},
                    31'h7FFF_FFFF, {32'd0, 32'd0, 32'h8000_0000}, 1'b1};
    dir_tbl[6]  = '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
                    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 31'h7FFF_FFFF,
                    '0, 1'b0};
    dir_tbl[7]  = '{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
                    '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0}, 31'd1, '0, 1'b0};
    dir_tbl[8]  = '{'{32'd3, 32'd4, 32'd0}, '{32'd0, 32'd0, 32'd0}, 31'd10,
                    '0, 1'b0};
    dir_tbl[9]  = '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                    '{32'd0, 32'd0, 32'd0}, 31'h5555_5555, '0, 1'b0};
    dir_tbl[10] = '{'{32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678},
                    '{32'h5555_5555, 32'hAAAA_AAAA, 32'h8765_4321}, 31'h2AAA_AAAA,
                    '0, 1'b0};
    dir_tbl[11] = '{'{32'd0, 32'd0, 32'd1}, '{32'd0, 32'd0, 32'd0}, 31'h7FFF_FFFF,
                    '0, 1'b0};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_gap_pct = 6;
    recv_gap_pct = 81;
    foreach (dir_tbl[i]) begin
      for (int a = 0; a < 3; a++) begin
        v.pt[a] = dir_tbl[i].p[a];
        v.ctr[a] = dir_tbl[i].c[a];
      end
      v.len = dir_tbl[i].len;
      chk = predict_move(v);
      if (dir_tbl[i].typed && chk.xyz !== dir_tbl[i].xyz) begin
        $display("%0t table row %0d: expected %h, got %h", $time, i,
                 dir_tbl[i].xyz, chk.xyz);
        err_cnt++;
      end
      send_vec(v);
    end
    run_random(350);
    drain();

    send_gap_pct = 81;
    recv_gap_pct = 6;
    run_random(300);
    drain();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_off = 1'b1;
    run_random(450);
    s_tvalid <= 1'b0;
    feed_done = 1'b1;
  end

  always @(negedge clk) begin
    if (hold_off) begin
      m_tready <= 1'b0;
      repeat (300) @(negedge clk);
      hold_off = 1'b0;
    end else begin
      m_tready <= !rst && ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    vec_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (moved_q.size() == 0) begin
        $display("%0t unexpected word: xyz=%h flags=%b", $time, m_tdata, m_tuser);
        err_cnt++;
      end else begin
        want = moved_q.pop_front();
        for (int i = 0; i < 3; i++)
          if (m_tdata[32*i +: 32] !== want.xyz[32*i +: 32]) begin
            $display("%0t coord %0d: expected %h, got %h", $time, i,
                     want.xyz[32*i +: 32], m_tdata[32*i +: 32]);
            err_cnt++;
          end
        if (m_tuser[0] !== want.flags[0]) begin
          $display("%0t degenerate: expected %b, got %b", $time, want.flags[0], m_tuser[0]);
          err_cnt++;
        end
        if (m_tuser[1] !== want.flags[1]) begin
          $display("%0t saturated: expected %b, got %b", $time, want.flags[1], m_tuser[1]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    wait (feed_done);
    while (moved_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== point_to_fixed_distance_3d.f =====
src/ptfd_pkg.sv
src/ptfd_sqrt.sv
src/ptfd_div.sv
src/ptfd_lane.sv
src/point_to_fixed_distance_3d.sv
test/tb_top.sv
